### rtl/gobh_pkg.sv
package gobh_pkg;

  // Widths of the fixed fields
  localparam int PIX_W     = 8;
  localparam int CNT_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 7;

  // Only orientation bins 0..4 can receive votes (dx, dy are non-negative)
  localparam int VOTE_BINS = 5;
  localparam int BIN_IDX_W = 3;

  // dx^2 + dy^2 for 8-bit dx, dy fits in this many bits
  localparam int SQ_W = 17;

  // tan(k*pi/9) thresholds for k = 1..4, scaled by 2^TAN_SHIFT
  localparam int TAN_SHIFT = 32;
  localparam int TAN_W     = 35;
  localparam int ORI_W     = PIX_W + TAN_W;
  localparam logic [TAN_W-1:0] TAN_THR [4] = '{
    35'd1563240253, 35'd3603905474, 35'd7439101574, 35'd24357969942
  };

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_STRIDE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_STRIDE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS     = 3'd5;

  // Neighbor fetch order
  localparam logic [2:0] NB_LEFT  = 3'd0;
  localparam logic [2:0] NB_RIGHT = 3'd1;
  localparam logic [2:0] NB_UP    = 3'd2;
  localparam logic [2:0] NB_DOWN  = 3'd3;
  localparam logic [2:0] NB_LAST  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLK,
    ST_CELL,
    ST_READ,
    ST_MAGW,
    ST_ARG,
    ST_CNT,
    ST_EMIT
  } gobh_state_e;

  typedef struct packed {
    logic             start;
    logic [PIX_W-1:0] dx;
    logic [PIX_W-1:0] dy;
  } gobh_mag_req_t;

  typedef struct packed {
    logic                 done;
    logic [BIN_IDX_W-1:0] bin;
  } gobh_mag_rsp_t;

endpackage

### rtl/gradient_orientation_block_histogram_unit.sv
// Gradient orientation block histogram.
// Load a square grey image column by column: one pixel word per accepted
// start (start high while busy is low), one word per cycle. The word with
// last_pixel_i set starts the compute pass when the block size is below the
// image size, and raises busy until the pass ends. Configuration writes go
// through cfg_valid_i / cfg_ready_o with a register index; ready is always
// high and writes belong to idle periods. Each block, up to MAX_BLOCKS per
// image, gives one result word on count_bin*_o / last_block_o, marked by a
// one-cycle result_valid_o; the receiver cannot stall, so each word is
// shown exactly once. last_block_o marks the final word of the image.
// Compute time per pixel is set by the four frame store reads and the
// bit-serial square root of the shared magnitude unit, plus the steps
// per cell and per block. Each result word is registered from the emit
// state that follows the count of the last cell of its block. Reset
// restores register defaults and the load position; the frame store
// contents are not cleared.
module gradient_orientation_block_histogram_unit #(
  parameter int MAX_IMAGE  = 64,
  parameter int MAX_BINS   = 9,
  parameter int MAX_BLOCKS = 64,
  parameter int FRAC_BITS  = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [gobh_pkg::PIX_W-1:0]     pixel_i,
  input  logic                           last_pixel_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gobh_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gobh_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output logic                           result_valid_o,
  output logic [gobh_pkg::CNT_W-1:0]     count_bin0_o,
  output logic [gobh_pkg::CNT_W-1:0]     count_bin1_o,
  output logic [gobh_pkg::CNT_W-1:0]     count_bin2_o,
  output logic [gobh_pkg::CNT_W-1:0]     count_bin3_o,
  output logic [gobh_pkg::CNT_W-1:0]     count_bin4_o,
  output logic [gobh_pkg::CNT_W-1:0]     count_bin5_o,
  output logic [gobh_pkg::CNT_W-1:0]     count_bin6_o,
  output logic [gobh_pkg::CNT_W-1:0]     count_bin7_o,
  output logic [gobh_pkg::CNT_W-1:0]     count_bin8_o,
  output logic                           last_block_o
);

  localparam int DEPTH = MAX_IMAGE * MAX_IMAGE;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = AW + 1;
  localparam int VW    = gobh_pkg::SQ_W + 2 * FRAC_BITS;
  localparam int RW    = (VW + 1) / 2;
  localparam int MW    = RW + 1;
  localparam int SW    = MW + 10;
  localparam int EW    = $clog2(MAX_BLOCKS + 1);
  localparam int NV    = gobh_pkg::VOTE_BINS;
  localparam int PW    = gobh_pkg::PIX_W;
  localparam int BW    = gobh_pkg::BIN_IDX_W;

  // configuration registers
  logic [6:0] image_size_q, block_size_q, block_stride_q;
  logic [4:0] cell_size_q, cell_stride_q;
  logic [3:0] num_bins_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q   <= 7'd64;
      cell_size_q    <= 5'd3;
      cell_stride_q  <= 5'd3;
      block_size_q   <= 7'd36;
      block_stride_q <= 7'd18;
      num_bins_q     <= 4'd9;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        gobh_pkg::CFG_IMAGE_SIZE:   image_size_q   <= cfg_data_i;
        gobh_pkg::CFG_CELL_SIZE:    cell_size_q    <= cfg_data_i[4:0];
        gobh_pkg::CFG_CELL_STRIDE:  cell_stride_q  <= cfg_data_i[4:0];
        gobh_pkg::CFG_BLOCK_SIZE:   block_size_q   <= cfg_data_i;
        gobh_pkg::CFG_BLOCK_STRIDE: block_stride_q <= cfg_data_i;
        gobh_pkg::CFG_NUM_BINS:     num_bins_q     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // effective geometry: clamp size, zero strides step by one
  logic [6:0]  n, bs, bst;
  logic [4:0]  cs, cst;
  logic [3:0]  nb_c, nbv;
  logic [13:0] n_sq;
  logic [TW-1:0] total;

  always_comb begin
    if (image_size_q == '0) begin
      n = 7'd1;
    end else if (10'(image_size_q) > 10'(MAX_IMAGE)) begin
      n = 7'(MAX_IMAGE);
    end else begin
      n = image_size_q;
    end
    bs  = block_size_q;
    bst = (block_stride_q == '0) ? 7'd1 : block_stride_q;
    cs  = cell_size_q;
    cst = (cell_stride_q == '0) ? 5'd1 : cell_stride_q;
    if (num_bins_q == '0) begin
      nb_c = 4'd1;
    end else if (num_bins_q > 4'(MAX_BINS)) begin
      nb_c = 4'(MAX_BINS);
    end else begin
      nb_c = num_bins_q;
    end
    // bins past the vote bins stay zero and never win the argmax
    nbv = (nb_c > 4'(NV)) ? 4'(NV) : nb_c;
  end

  assign n_sq  = 14'(n) * 14'(n);
  assign total = TW'(n_sq);

  gobh_pkg::gobh_state_e state_q, state_d;

  // walk registers
  logic [6:0]    bx_q, by_q, cx_q, cy_q;
  logic [4:0]    x_q, y_q;
  logic [2:0]    rd_cnt_q;
  logic          zf_q;
  logic [PW-1:0] nbr_q [3];
  logic [BW-1:0] v_q, best_q;
  logic [SW-1:0] best_val_q;
  logic [EW-1:0] emitted_q;
  logic [AW-1:0] lc_q;
  logic [SW-1:0] sums_q [NV];
  logic [gobh_pkg::CNT_W-1:0] counts_q [NV];
  logic [gobh_pkg::CNT_W-1:0] out_cnt_q [NV];
  logic          out_last_q, res_valid_q;

  logic accept;
  assign accept = start && !busy;

  // load position
  logic [AW-1:0] lc_cur;
  logic [TW-1:0] lc_inc;
  assign lc_cur = (TW'(lc_q) >= total) ? '0 : lc_q;
  assign lc_inc = TW'(lc_cur) + TW'(1);

  // loop conditions
  logic blk_any, cell_any, y_more, x_more, cy_more, cx_more, by_more, bx_more;
  logic arg_more, emit_last;
  assign blk_any   = bs < n;
  assign cell_any  = 7'(cs) < bs;
  assign y_more    = 5'(y_q) + 5'd1 < cs;
  assign x_more    = 5'(x_q) + 5'd1 < cs;
  assign cy_more   = 8'(cy_q) + 8'(cst) + 8'(cs) < 8'(bs);
  assign cx_more   = 8'(cx_q) + 8'(cst) + 8'(cs) < 8'(bs);
  assign by_more   = 9'(by_q) + 9'(bst) + 9'(bs) < 9'(n);
  assign bx_more   = 9'(bx_q) + 9'(bst) + 9'(bs) < 9'(n);
  assign arg_more  = 4'(v_q) + 4'd1 < nbv;
  assign emit_last = (!by_more && !bx_more) || (emitted_q == EW'(MAX_BLOCKS - 1));

  // pixel and neighbor address
  logic [7:0]  px, py, ax, ay;
  logic        nb_out;
  logic [15:0] addr_full;
  logic [AW-1:0] rd_addr;
  logic [PW-1:0] rd_data, down_v, dx_c, dy_c;

  assign px = 8'(bx_q) + 8'(cx_q) + 8'(x_q);
  assign py = 8'(by_q) + 8'(cy_q) + 8'(y_q);

  always_comb begin
    ax     = px;
    ay     = py;
    nb_out = 1'b0;
    unique case (rd_cnt_q)
      gobh_pkg::NB_LEFT: begin
        ax     = px - 8'd1;
        nb_out = (px == '0);
      end
      gobh_pkg::NB_RIGHT: begin
        ax     = px + 8'd1;
        nb_out = (px + 8'd1 == 8'(n));
      end
      gobh_pkg::NB_UP: begin
        ay     = py - 8'd1;
        nb_out = (py == '0);
      end
      gobh_pkg::NB_DOWN: begin
        ay     = py + 8'd1;
        nb_out = (py + 8'd1 == 8'(n));
      end
      default: ;
    endcase
  end

  assign addr_full = 16'(ax) * 16'(n) + 16'(ay);
  assign rd_addr   = AW'(addr_full);

  gobh_frame_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (accept),
    .wr_addr_i(lc_cur),
    .wr_data_i(pixel_i),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // absolute gradients once the last neighbor lands
  assign down_v = zf_q ? '0 : rd_data;
  assign dx_c   = (nbr_q[0] >= nbr_q[1]) ? nbr_q[0] - nbr_q[1] : nbr_q[1] - nbr_q[0];
  assign dy_c   = (nbr_q[2] >= down_v) ? nbr_q[2] - down_v : down_v - nbr_q[2];

  gobh_pkg::gobh_mag_req_t mag_req;
  gobh_pkg::gobh_mag_rsp_t mag_rsp;
  logic [MW-1:0]           mag;

  gobh_mag_unit #(
    .FRAC_BITS(FRAC_BITS),
    .MW       (MW)
  ) u_mag (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mag_req),
    .rsp_o (mag_rsp),
    .mag_o (mag)
  );

  // single read port on the vote sums: the new vote's bin, or the argmax index
  logic [BW-1:0] sel_idx;
  logic [SW-1:0] sel_sum;
  assign sel_idx = (state_q == gobh_pkg::ST_MAGW) ? mag_rsp.bin : v_q;
  assign sel_sum = sums_q[sel_idx];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gobh_pkg::ST_IDLE: begin
        if (accept && last_pixel_i && blk_any) state_d = gobh_pkg::ST_BLK;
      end
      gobh_pkg::ST_BLK: begin
        state_d = cell_any ? gobh_pkg::ST_CELL : gobh_pkg::ST_EMIT;
      end
      gobh_pkg::ST_CELL: begin
        state_d = (cs != '0) ? gobh_pkg::ST_READ : gobh_pkg::ST_ARG;
      end
      gobh_pkg::ST_READ: begin
        if (rd_cnt_q == gobh_pkg::NB_LAST) state_d = gobh_pkg::ST_MAGW;
      end
      gobh_pkg::ST_MAGW: begin
        if (mag_rsp.done) begin
          state_d = (y_more || x_more) ? gobh_pkg::ST_READ : gobh_pkg::ST_ARG;
        end
      end
      gobh_pkg::ST_ARG: begin
        if (!arg_more) state_d = gobh_pkg::ST_CNT;
      end
      gobh_pkg::ST_CNT: begin
        state_d = (cy_more || cx_more) ? gobh_pkg::ST_CELL : gobh_pkg::ST_EMIT;
      end
      gobh_pkg::ST_EMIT: begin
        state_d = emit_last ? gobh_pkg::ST_IDLE : gobh_pkg::ST_BLK;
      end
      default: state_d = gobh_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy          = (state_q != gobh_pkg::ST_IDLE);
    mag_req.start = (state_q == gobh_pkg::ST_READ) && (rd_cnt_q == gobh_pkg::NB_LAST);
    mag_req.dx    = dx_c;
    mag_req.dy    = dy_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gobh_pkg::ST_IDLE;
      lc_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == gobh_pkg::ST_EMIT);
      if (accept) begin
        // wrap at the end of the image; restart after the last pixel
        if (last_pixel_i || lc_inc >= total) begin
          lc_q <= '0;
        end else begin
          lc_q <= AW'(lc_inc);
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      gobh_pkg::ST_IDLE: begin
        bx_q      <= '0;
        by_q      <= '0;
        emitted_q <= '0;
      end
      gobh_pkg::ST_BLK: begin
        for (int i = 0; i < NV; i++) counts_q[i] <= '0;
        cx_q <= '0;
        cy_q <= '0;
      end
      gobh_pkg::ST_CELL: begin
        for (int i = 0; i < NV; i++) sums_q[i] <= '0;
        x_q      <= '0;
        y_q      <= '0;
        rd_cnt_q <= '0;
        v_q      <= '0;
      end
      gobh_pkg::ST_READ: begin
        rd_cnt_q <= rd_cnt_q + 3'd1;
        zf_q     <= nb_out;
        if (rd_cnt_q != gobh_pkg::NB_LEFT && rd_cnt_q != gobh_pkg::NB_LAST) begin
          nbr_q[2'(rd_cnt_q - 3'd1)] <= zf_q ? '0 : rd_data;
        end
      end
      gobh_pkg::ST_MAGW: begin
        if (mag_rsp.done) begin
          sums_q[sel_idx] <= sel_sum + SW'(mag);
          rd_cnt_q        <= '0;
          v_q             <= '0;
          // advance y inner, x outer
          if (y_more) begin
            y_q <= y_q + 5'd1;
          end else begin
            y_q <= '0;
            x_q <= x_q + 5'd1;
          end
        end
      end
      gobh_pkg::ST_ARG: begin
        // lowest index wins ties: take only a strictly larger sum
        if (v_q == '0 || sel_sum > best_val_q) begin
          best_q     <= v_q;
          best_val_q <= sel_sum;
        end
        v_q <= v_q + BW'(1);
      end
      gobh_pkg::ST_CNT: begin
        counts_q[best_q] <= counts_q[best_q] + gobh_pkg::CNT_W'(1);
        if (cy_more) begin
          cy_q <= cy_q + 7'(cst);
        end else begin
          cy_q <= '0;
          cx_q <= cx_q + 7'(cst);
        end
      end
      gobh_pkg::ST_EMIT: begin
        for (int i = 0; i < NV; i++) out_cnt_q[i] <= counts_q[i];
        out_last_q <= emit_last;
        emitted_q  <= emitted_q + EW'(1);
        if (by_more) begin
          by_q <= by_q + bst;
        end else begin
          by_q <= '0;
          bx_q <= bx_q + bst;
        end
      end
      default: ;
    endcase
  end

  assign result_valid_o = res_valid_q;
  assign count_bin0_o   = out_cnt_q[0];
  assign count_bin1_o   = out_cnt_q[1];
  assign count_bin2_o   = out_cnt_q[2];
  assign count_bin3_o   = out_cnt_q[3];
  assign count_bin4_o   = out_cnt_q[4];
  // orientation bins above four never receive votes
  assign count_bin5_o   = '0;
  assign count_bin6_o   = '0;
  assign count_bin7_o   = '0;
  assign count_bin8_o   = '0;
  assign last_block_o   = out_last_q;

  // the magnitude unit only answers a request from the wait state
  a_mag_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_rsp.done |-> state_q == gobh_pkg::ST_MAGW)
    else $error("magnitude result outside wait state");

  // every result word follows a block emit
  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q) == gobh_pkg::ST_EMIT)
    else $error("result word without block emit");

  // the final block word frees the block for the next image
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_block_o |-> !busy)
    else $error("still busy after last block");

endmodule

### rtl/gobh_frame_store.sv
module gobh_frame_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [gobh_pkg::PIX_W-1:0] wr_data_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [gobh_pkg::PIX_W-1:0] rd_data_o
);

  logic [gobh_pkg::PIX_W-1:0] mem [DEPTH];
  logic [gobh_pkg::PIX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/gobh_mag_unit.sv
module gobh_mag_unit #(
  parameter int FRAC_BITS = 8,
  parameter int MW        = 18
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  gobh_pkg::gobh_mag_req_t req_i,
  output gobh_pkg::gobh_mag_rsp_t rsp_o,
  output logic [MW-1:0]           mag_o
);

  localparam int VW  = gobh_pkg::SQ_W + 2 * FRAC_BITS;
  localparam int RW  = (VW + 1) / 2;
  localparam int STW = $clog2(RW + 4);
  localparam logic [STW-1:0] ST_LAST = STW'(RW + 2);

  logic                       active_q, active_d;
  logic [STW-1:0]             step_q, step_d;
  logic [gobh_pkg::PIX_W-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [VW-1:0]              rem_q, rem_d, root_q, root_d, bitpos_q, bitpos_d;
  logic [gobh_pkg::BIN_IDX_W-1:0] bin_q, bin_d;
  logic                       done_q, done_d;
  logic [MW-1:0]              mag_q, mag_d;

  logic [gobh_pkg::PIX_W-1:0]   op;
  logic [2*gobh_pkg::PIX_W-1:0] sq;
  logic [VW-1:0]                trial;
  logic [1:0]                   ori_k;
  logic [gobh_pkg::ORI_W-1:0]   ori_lhs, ori_rhs;
  logic [STW-1:0]               step_m2;

  // one 8x8 squarer, shared by dx and dy
  assign op      = (step_q == '0) ? dx_q : dy_q;
  assign sq      = op * op;
  assign trial   = root_q + bitpos_q;
  assign step_m2 = step_q - STW'(2);
  assign ori_k   = step_m2[1:0];
  assign ori_lhs = {dx_q, {gobh_pkg::TAN_SHIFT{1'b0}}} & {gobh_pkg::ORI_W{1'b1}};
  assign ori_rhs = {{gobh_pkg::PIX_W{1'b0}}, gobh_pkg::TAN_THR[ori_k]}
                 * {{gobh_pkg::TAN_W{1'b0}}, dy_q};

  always_comb begin
    active_d = active_q;
    step_d   = step_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    rem_d    = rem_q;
    root_d   = root_q;
    bitpos_d = bitpos_q;
    bin_d    = bin_q;
    done_d   = 1'b0;
    mag_d    = mag_q;
    if (!active_q) begin
      if (req_i.start) begin
        active_d = 1'b1;
        step_d   = '0;
        dx_d     = req_i.dx;
        dy_d     = req_i.dy;
        bin_d    = '0;
      end
    end else begin
      step_d = step_q + STW'(1);
      if (step_q == '0) begin
        rem_d = VW'(sq);
      end else if (step_q == STW'(1)) begin
        rem_d    = (rem_q + VW'(sq)) << (2 * FRAC_BITS);
        root_d   = '0;
        bitpos_d = VW'(1) << (2 * (RW - 1));
      end else if (step_q != ST_LAST) begin
        // one result bit per cycle
        if (rem_q >= trial) begin
          rem_d  = rem_q - trial;
          root_d = (root_q >> 1) + bitpos_q;
        end else begin
          root_d = root_q >> 1;
        end
        bitpos_d = bitpos_q >> 2;
        // orientation threshold k, one per cycle on the first four steps
        if (step_q < STW'(6) && ori_lhs >= ori_rhs) begin
          bin_d = gobh_pkg::BIN_IDX_W'(ori_k) + gobh_pkg::BIN_IDX_W'(1);
        end
      end else begin
        mag_d = MW'(root_q) + MW'(rem_q > root_q);
        if (dx_q == '0 && dy_q == '0) begin
          bin_d = '0;
        end
        done_d   = 1'b1;
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      step_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      step_q   <= step_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    bitpos_q <= bitpos_d;
    bin_q    <= bin_d;
    mag_q    <= mag_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.bin  = bin_q;
  assign mag_o      = mag_q;

endmodule

### tb/tb_gradient_orientation_block_histogram_unit.sv
`timescale 1ns / 1ps

module tb_gradient_orientation_block_histogram_unit;

  localparam int PW         = gobh_pkg::PIX_W;
  localparam int CW         = gobh_pkg::CNT_W;
  localparam int IW         = gobh_pkg::CFG_IDX_W;
  localparam int DW         = gobh_pkg::CFG_DAT_W;
  localparam int N_BINS     = 9;
  localparam int STORE_SZ   = 4096;
  localparam int MAX_BLK    = 64;
  localparam int STALL_MAX  = 200000;
  localparam int SETTLE_CYC = 60;
  // Index that decodes to no register; writes to it must be ignored
  localparam logic [IW-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [N_BINS-1:0][CW-1:0] cnt;
    logic                      last;
  } block_hist_t;

  // One row of the directed stimulus table. flat_blocks >= 0 marks the closing
  // pixel of a flat image: each of that many blocks reports one cell in bin 0.
  typedef struct {
    logic [PW-1:0] px;
    logic          last;
    int            flat_blocks;
  } pixel_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  logic [PW-1:0]  pixel_i = '0;
  logic           last_pixel_i = 1'b0;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [IW-1:0]  cfg_index_i = '0;
  logic [DW-1:0]  cfg_data_i = '0;
  logic           result_valid_o;
  logic [CW-1:0]  count_bin0_o, count_bin1_o, count_bin2_o, count_bin3_o,
                  count_bin4_o, count_bin5_o, count_bin6_o, count_bin7_o,
                  count_bin8_o;
  logic           last_block_o;

  gradient_orientation_block_histogram_unit uut (
    .clk_i, .rst_ni, .start, .busy, .pixel_i, .last_pixel_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .result_valid_o, .count_bin0_o, .count_bin1_o, .count_bin2_o,
    .count_bin3_o, .count_bin4_o, .count_bin5_o, .count_bin6_o,
    .count_bin7_o, .count_bin8_o, .last_block_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the registers and of the frame store
  logic [6:0]    img_reg;
  logic [4:0]    cell_reg, cstride_reg;
  logic [6:0]    blk_reg, bstride_reg;
  logic [3:0]    bins_reg;
  logic [PW-1:0] frame_mem [STORE_SZ];
  bit            frame_written [STORE_SZ];
  int unsigned   load_pos;

  block_hist_t hist_expect_q[$];
  int          errors;
  int          stall_cycles;
  int          sender_idle_pct;

  function automatic int unsigned image_side();
    int unsigned n;
    n = img_reg;
    if (n == 0) n = 1;
    if (n > 64) n = 64;
    return n;
  endfunction

  function automatic int unsigned frame_pix(int unsigned n, int x, int y);
    if (x < 0 || y < 0 || x >= int'(n) || y >= int'(n)) return 0;
    return frame_mem[x * n + y];
  endfunction

  // Square root of (dx^2 + dy^2) << 16, rounded to nearest
  function automatic longint unsigned grad_magnitude(int unsigned dx, int unsigned dy);
    longint unsigned v, r, bitv, rem;
    v = (longint'(dx) * dx + longint'(dy) * dy) << 16;
    r = 0;
    rem = v;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= r + bitv) begin
        rem -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    if (v - r * r > r) r++;
    return r;
  endfunction

  // Orientation bin: compare dx/dy with tan(k*pi/9) scaled by 10^12
  function automatic int unsigned grad_bin(int unsigned dx, int unsigned dy);
    longint unsigned lim [4];
    int unsigned b;
    lim = '{64'd363970234266, 64'd839099631177, 64'd1732050807569, 64'd5671281819618};
    b = 0;
    if (dy == 0) return (dx != 0) ? 4 : 0;
    for (int k = 0; k < 4; k++)
      if (longint'(dx) * 64'd1000000000000 >= longint'(dy) * lim[k]) b = k + 1;
    return b;
  endfunction

  function automatic bit frame_ready(int unsigned n);
    for (int i = 0; i < n * n; i++)
      if (!frame_written[i]) return 0;
    return 1;
  endfunction

  // Store one pixel; on the closing pixel compute the block histograms
  task automatic predict_pixel(input logic [PW-1:0] px, input logic lastp,
                               output block_hist_t res[$]);
    int unsigned n, total, cs, bs, cst, bst, nb, best;
    int          px_x, px_y, gx, gy;
    int unsigned dx, dy, b;
    longint unsigned sums [N_BINS];
    int unsigned     cnt [N_BINS];
    block_hist_t     h;
    res = {};
    n = image_side();
    total = n * n;
    cs = cell_reg;
    bs = blk_reg;
    cst = (cstride_reg != 0) ? cstride_reg : 1;
    bst = (bstride_reg != 0) ? bstride_reg : 1;
    nb = (bins_reg == 0) ? 1 : ((bins_reg > N_BINS) ? N_BINS : bins_reg);
    if (load_pos >= total) load_pos = 0;
    frame_mem[load_pos] = px;
    frame_written[load_pos] = 1;
    load_pos++;
    if (load_pos >= total) load_pos = 0;
    if (!lastp) return;
    load_pos = 0;
    for (int unsigned bx = 0; bx + bs < n; bx += bst) begin
      for (int unsigned by = 0; by + bs < n; by += bst) begin
        foreach (cnt[j]) cnt[j] = 0;
        for (int unsigned cx = 0; cx + cs < bs; cx += cst) begin
          for (int unsigned cy = 0; cy + cs < bs; cy += cst) begin
            foreach (sums[j]) sums[j] = 0;
            for (int unsigned x = 0; x < cs; x++) begin
              for (int unsigned y = 0; y < cs; y++) begin
                px_x = bx + cx + x;
                px_y = by + cy + y;
                gx = int'(frame_pix(n, px_x - 1, px_y)) - int'(frame_pix(n, px_x + 1, px_y));
                gy = int'(frame_pix(n, px_x, px_y - 1)) - int'(frame_pix(n, px_x, px_y + 1));
                dx = (gx < 0) ? -gx : gx;
                dy = (gy < 0) ? -gy : gy;
                b = grad_bin(dx, dy);
                sums[b] += grad_magnitude(dx, dy);
              end
            end
            best = 0;
            for (int unsigned v = 1; v < nb; v++)
              if (sums[v] > sums[best]) best = v;
            cnt[best] = (cnt[best] + 1) & 12'hFFF;
          end
        end
        if (res.size() < MAX_BLK) begin
          h = '0;
          for (int j = 0; j < N_BINS; j++) h.cnt[j] = CW'(cnt[j]);
          res = {res, h};
        end
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
  endtask

  // Offer one pixel word and hold it until the block takes it
  task automatic send_pixel(input logic [PW-1:0] px, input logic lastp,
                            input int flat_blocks);
    block_hist_t res[$];
    block_hist_t h;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start <= 1'b1;
    pixel_i <= px;
    last_pixel_i <= lastp;
    do @(posedge clk_i); while (busy);
    predict_pixel(px, lastp, res);
    if (flat_blocks >= 0) begin
      res = {};
      for (int i = 0; i < flat_blocks; i++) begin
        h = '0;
        h.cnt[0] = 12'd1;
        h.last = (i == flat_blocks - 1);
        res = {res, h};
      end
    end
    foreach (res[i]) hist_expect_q = {hist_expect_q, res[i]};
  endtask

  // Drop start and hold off until every expected word is in and busy falls
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (hist_expect_q.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      gobh_pkg::CFG_IMAGE_SIZE:   img_reg = val;
      gobh_pkg::CFG_CELL_SIZE:    cell_reg = val[4:0];
      gobh_pkg::CFG_CELL_STRIDE:  cstride_reg = val[4:0];
      gobh_pkg::CFG_BLOCK_SIZE:   blk_reg = val;
      gobh_pkg::CFG_BLOCK_STRIDE: bstride_reg = val;
      gobh_pkg::CFG_NUM_BINS:     bins_reg = val[3:0];
      default: ;
    endcase
    // cfg_valid_i stays low before the next write
    @(posedge clk_i);
  endtask

  task automatic write_all(input int img, input int cs, input int cst, input int bs,
                           input int bst, input int nb);
    write_reg(gobh_pkg::CFG_IMAGE_SIZE, DW'(img));
    write_reg(gobh_pkg::CFG_CELL_SIZE, DW'(cs));
    write_reg(gobh_pkg::CFG_CELL_STRIDE, DW'(cst));
    write_reg(gobh_pkg::CFG_BLOCK_SIZE, DW'(bs));
    write_reg(gobh_pkg::CFG_BLOCK_STRIDE, DW'(bst));
    write_reg(gobh_pkg::CFG_NUM_BINS, DW'(nb));
  endtask

  function automatic logic [PW-1:0] rand_pixel();
    // Lean on the extremes so zero and saturated gradients show up often
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return PW'($urandom_range(255));
    endcase
  endfunction

  // Load one image: usually exactly full, sometimes cut short or overrun
  task automatic send_image(input int mode);
    int unsigned total, cnt;
    total = image_side() * image_side();
    cnt = total;
    if (mode == 1 && total > 1 && frame_ready(image_side())) cnt = $urandom_range(1, total - 1);
    if (mode == 2) cnt = total + $urandom_range(1, 5);
    for (int unsigned i = 0; i < cnt; i++) send_pixel(rand_pixel(), i == cnt - 1, -1);
  endtask

  // Compare each shown word with the oldest expectation; count idle cycles
  always @(posedge clk_i) begin
    block_hist_t got, want;
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
          $display("%0t watchdog: no word moved for %0d cycles", $time, STALL_MAX);
          $display("RESULT: ERROR");
          $finish;
        end
      end
      if (result_valid_o) begin
        got.cnt = {count_bin8_o, count_bin7_o, count_bin6_o, count_bin5_o, count_bin4_o,
                   count_bin3_o, count_bin2_o, count_bin1_o, count_bin0_o};
        got.last = last_block_o;
        if (hist_expect_q.size() == 0) begin
          $display("%0t unexpected histogram word %h", $time, got);
          errors++;
        end else begin
          want = hist_expect_q.pop_front();
          for (int j = 0; j < N_BINS; j++)
            if (got.cnt[j] !== want.cnt[j]) begin
              $display("%0t count_bin%0d expected %0d actual %0d", $time, j,
                       want.cnt[j], got.cnt[j]);
              errors++;
            end
          if (got.last !== want.last) begin
            $display("%0t last_block expected %0b actual %0b", $time, want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    pixel_row_t table_rows[$];
    pixel_row_t row;
    int sent, n, bs;
    errors = 0;
    stall_cycles = 0;
    sender_idle_pct = 12;
    img_reg = 7'd64; cell_reg = 5'd3; cstride_reg = 5'd3;
    blk_reg = 7'd36; bstride_reg = 7'd18; bins_reg = 4'd9;
    load_pos = 0;
    foreach (frame_written[i]) frame_written[i] = 0;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: 4x4 image, 2x2 blocks at stride 1, one 1x1 cell each.
    // Flat image first (every block votes bin 0), then a short reload that
    // ends early with hard edges, checked against the predictor.
    write_all(4, 1, 1, 2, 1, 9);
    for (int i = 0; i < 16; i++) begin
      row.px = 8'd0;
      row.last = (i == 15);
      row.flat_blocks = (i == 15) ? 4 : -1;
      table_rows = {table_rows, row};
    end
    for (int i = 0; i < 5; i++) begin
      row.px = i[0] ? 8'h00 : 8'hFF;
      row.last = (i == 4);
      row.flat_blocks = -1;
      table_rows = {table_rows, row};
    end
    foreach (table_rows[i]) send_pixel(table_rows[i].px, table_rows[i].last,
                                       table_rows[i].flat_blocks);
    sent = table_rows.size();
    drain();

    // Random part: mostly full images with random content, some cut short or
    // overrun; reconfigure now and then while idle
    while (sent < 368) begin
      if (sent > 246) begin
        sender_idle_pct = 0;
      end else if (sent > 123) begin
        sender_idle_pct = 49;
      end
      if ($urandom_range(99) < 35) begin
        drain();
        n = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
        bs = ($urandom_range(7) == 0) ? $urandom_range(0, 12) : $urandom_range(0, (n > 1) ? n - 1 : 0);
        write_all(n, $urandom_range(0, 5), $urandom_range(0, 4), bs,
                  $urandom_range(0, 6), $urandom_range(0, 15));
        if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, DW'($urandom_range(127)));
      end
      case ($urandom_range(9))
        0: send_image(1);
        1: send_image(2);
        default: send_image(0);
      endcase
      sent += image_side() * image_side();
      // Pause now and then until everything expected has come back
      if ($urandom_range(4) == 0) drain();
    end

    // Largest image: zero-size blocks give empty histograms, capped at 64;
    // no cell reads the store, so one closing pixel is enough
    drain();
    write_all(127, 31, 31, 0, 1, 0);
    send_pixel(rand_pixel(), 1'b1, -1);

    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/gobh_pkg.sv
rtl/gobh_frame_store.sv
rtl/gobh_mag_unit.sv
rtl/gradient_orientation_block_histogram_unit.sv
tb/tb_gradient_orientation_block_histogram_unit.sv
